[design/bdc_pkg.sv]
// Shared types and constants for the block-diagonal dense-to-COO converter.
// Used by bdc_scan and block_diagonal_dense_to_coo; depends on nothing.
package bdc_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int SIZE_W    = 17;
  localparam int IDX_W     = 20;
  localparam int WORD_W    = 32;
  localparam int ENTRY_W   = 30;
  localparam int COUNT_W   = 31;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 168;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1) << (COUNT_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_SLICES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] slices;
  } size_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic [WORD_W-1:0]  value_real;
    logic [WORD_W-1:0]  value_imag;
    logic               entry_valid;
    logic [ENTRY_W-1:0] entry_number;
    logic               is_final;
    logic [COUNT_W-1:0] nonzero_total;
  } coo_entry_t;

endpackage

[design/bdc_scan.sv]
// Position tracker and entry builder: walks column, row and slice counters,
// tests each element for zero and forms the COO entry. Depends on bdc_pkg.
module bdc_scan #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_SLICES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  bdc_pkg::size_cfg_t              sizes,
  input  logic [bdc_pkg::WORD_W-1:0]      real_bits,
  input  logic [bdc_pkg::WORD_W-1:0]      imag_bits,
  output logic                            has_result,
  output bdc_pkg::coo_entry_t             entry
);
  import bdc_pkg::*;

  localparam int RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CPW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SPW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

  localparam logic [SIZE_W-1:0] MAX_R = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] MAX_C = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] MAX_S = SIZE_W'(MAX_SLICES);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (SIZE_W'(v) > maxv) begin
      r = maxv;
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

  logic [CPW-1:0]     col_pos, col_pos_next;
  logic [RPW-1:0]     row_pos, row_pos_next;
  logic [SPW-1:0]     slice_pos, slice_pos_next;
  logic [IDX_W-1:0]   row_base, row_base_next;
  logic [IDX_W-1:0]   col_base, col_base_next;
  logic [COUNT_W-1:0] nonzero_count, nonzero_count_next;

  logic [SIZE_W-1:0]  rows_eff, cols_eff, slices_eff;
  logic               nonzero, col_end, row_end, slice_end, last;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    rows_eff   = clamp_size(sizes.rows, MAX_R);
    cols_eff   = clamp_size(sizes.cols, MAX_C);
    slices_eff = clamp_size(sizes.slices, MAX_S);

    nonzero   = (|real_bits[WORD_W-2:0]) || (|imag_bits[WORD_W-2:0]);
    col_end   = (SIZE_W'(col_pos) + SIZE_W'(1)) >= cols_eff;
    row_end   = (SIZE_W'(row_pos) + SIZE_W'(1)) >= rows_eff;
    slice_end = (SIZE_W'(slice_pos) + SIZE_W'(1)) >= slices_eff;
    last      = col_end && row_end && slice_end;

    // The count stops once its top bit is set, which is exactly COUNT_MAX.
    if (nonzero && !nonzero_count[COUNT_W-1]) begin
      count_inc = nonzero_count + COUNT_W'(1);
    end else begin
      count_inc = nonzero_count;
    end

    has_result          = nonzero || last;
    entry.row_index     = nonzero ? row_base + IDX_W'(row_pos) : '0;
    entry.col_index     = nonzero ? col_base + IDX_W'(col_pos) : '0;
    entry.value_real    = nonzero ? real_bits : '0;
    entry.value_imag    = nonzero ? imag_bits : '0;
    entry.entry_valid   = nonzero;
    if (!nonzero) begin
      entry.entry_number = '0;
    end else if (nonzero_count[COUNT_W-1]) begin
      entry.entry_number = '1;
    end else begin
      entry.entry_number = nonzero_count[ENTRY_W-1:0];
    end
    entry.is_final      = last;
    entry.nonzero_total = count_inc;

    col_pos_next       = col_pos;
    row_pos_next       = row_pos;
    slice_pos_next     = slice_pos;
    row_base_next      = row_base;
    col_base_next      = col_base;
    nonzero_count_next = nonzero_count;
    if (accept) begin
      nonzero_count_next = count_inc;
      if (last) begin
        col_pos_next       = '0;
        row_pos_next       = '0;
        slice_pos_next     = '0;
        row_base_next      = '0;
        col_base_next      = '0;
        nonzero_count_next = '0;
      end else if (!col_end) begin
        col_pos_next = col_pos + CPW'(1);
      end else if (!row_end) begin
        col_pos_next = '0;
        row_pos_next = row_pos + RPW'(1);
      end else begin
        col_pos_next   = '0;
        row_pos_next   = '0;
        slice_pos_next = slice_pos + SPW'(1);
        row_base_next  = row_base + IDX_W'(rows_eff);
        col_base_next  = col_base + IDX_W'(cols_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos       <= '0;
      row_pos       <= '0;
      slice_pos     <= '0;
      row_base      <= '0;
      col_base      <= '0;
      nonzero_count <= '0;
    end else begin
      col_pos       <= col_pos_next;
      row_pos       <= row_pos_next;
      slice_pos     <= slice_pos_next;
      row_base      <= row_base_next;
      col_base      <= col_base_next;
      nonzero_count <= nonzero_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    nonzero_count <= COUNT_MAX)
    else $error("nonzero count passed its saturation value");

  a_restart_after_final: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> nonzero_count == '0 && col_pos == '0 && row_pos == '0
                       && slice_pos == '0 && row_base == '0 && col_base == '0)
    else $error("counters did not restart after the final element");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(nonzero_count) && $stable(col_pos) && $stable(row_pos)
                && $stable(slice_pos))
    else $error("position state moved without an accepted beat");
`endif

endmodule

[design/block_diagonal_dense_to_coo.sv]
// Each result is registered and appears on the master side in the cycle after its element beat is accepted.
// Throughput: one element per cycle; the single output register is refilled in the
// same cycle that it is drained, so input stalls only while a result waits unread.
// Elements that are zero and not final produce no output beat.
// Reset (synchronous, rst high) empties the output, sets all sizes to 1 and clears
// every position, base and count. Depends on bdc_pkg and bdc_scan.
module block_diagonal_dense_to_coo #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_SLICES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] real_bits, [63:32] imag_bits
  input  logic [bdc_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [19:0] row_index, [39:20] col_index, [71:40] value_real, [103:72] value_imag,
  // [133:104] entry_number, [164:134] nonzero_total, [167:165] zero
  output logic [bdc_pkg::M_TDATA_W-1:0]     m_tdata,
  // [0] entry_valid
  output logic                              m_tuser,
  // is_final
  output logic                              m_tlast
);
  import bdc_pkg::*;

  size_cfg_t  sizes;
  coo_entry_t entry;
  coo_entry_t out_entry;
  logic       has_result;
  logic       accept;
  logic       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sizes.rows   <= CFG_W'(1);
      sizes.cols   <= CFG_W'(1);
      sizes.slices <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROWS:   sizes.rows   <= cfg_data;
        REG_COLS:   sizes.cols   <= cfg_data;
        REG_SLICES: sizes.slices <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  bdc_scan #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_SLICES (MAX_SLICES)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sizes      (sizes),
    .real_bits  (s_tdata[WORD_W-1:0]),
    .imag_bits  (s_tdata[2*WORD_W-1:WORD_W]),
    .has_result (has_result),
    .entry      (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= has_result;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_entry <= entry;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_entry.entry_valid;
  assign m_tlast  = out_entry.is_final;
  assign m_tdata  = {3'b000,
                     out_entry.nonzero_total,
                     out_entry.entry_number,
                     out_entry.value_imag,
                     out_entry.value_real,
                     out_entry.col_index,
                     out_entry.row_index};

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while a result waits unread");

  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("beat without an entry that is not the final one");

  a_entry_below_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> COUNT_W'(m_tdata[133:104]) < m_tdata[164:134])
    else $error("entry number not below the running total");
`endif

endmodule
